// ===== design/mfb_pkg.sv =====
// Shared types, constants and the 5x7 font for the monochrome text renderer.
// Used by mfb_front, mfb_queue, mfb_back and mono_framebuffer_text_renderer_core.
`default_nettype none

package mfb_pkg;

  localparam int STORE_DEPTH       = 1024;
  localparam int ADDR_W            = 10;
  localparam int COORD_W           = 8;
  localparam int PAGE_W            = 5;
  localparam int GLYPH_COLS        = 5;
  localparam int GLYPH_ROWS        = 7;
  localparam int COL_W             = 3;
  localparam int QUEUE_DEPTH       = 2;
  localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);
  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_CHAR  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    glyph_t                glyph;
    logic [GLYPH_ROWS-1:0] row_en;
    logic [COL_W-1:0]      last_col;
    logic [ADDR_W-1:0]     read_addr;
  } queue_word_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_stat_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

  function automatic glyph_t mk_glyph(input logic [6:0] c0, input logic [6:0] c1,
                                      input logic [6:0] c2, input logic [6:0] c3,
                                      input logic [6:0] c4);
    return {c4, c3, c2, c1, c0};
  endfunction

  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    logic [7:0] folded;
    glyph_t     g;
    folded = code;
    if (code >= CH_LOWER_A && code <= CH_LOWER_Z) begin
      folded = code - CASE_OFFSET;
    end
    unique case (folded)
      8'h20: g = mk_glyph(7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
      8'h2D: g = mk_glyph(7'd8, 7'd8, 7'd8, 7'd8, 7'd8);
      8'h2E: g = mk_glyph(7'd0, 7'd96, 7'd96, 7'd0, 7'd0);
      8'h3A: g = mk_glyph(7'd0, 7'd54, 7'd54, 7'd0, 7'd0);
      8'h2F: g = mk_glyph(7'd32, 7'd16, 7'd8, 7'd4, 7'd2);
      8'h25: g = mk_glyph(7'd35, 7'd19, 7'd8, 7'd100, 7'd98);
      8'h30: g = mk_glyph(7'd62, 7'd81, 7'd73, 7'd69, 7'd62);
      8'h31: g = mk_glyph(7'd0, 7'd66, 7'd127, 7'd64, 7'd0);
      8'h32: g = mk_glyph(7'd66, 7'd97, 7'd81, 7'd73, 7'd70);
      8'h33: g = mk_glyph(7'd33, 7'd65, 7'd69, 7'd75, 7'd49);
      8'h34: g = mk_glyph(7'd24, 7'd20, 7'd18, 7'd127, 7'd16);
      8'h35: g = mk_glyph(7'd39, 7'd69, 7'd69, 7'd69, 7'd57);
      8'h36: g = mk_glyph(7'd60, 7'd74, 7'd73, 7'd73, 7'd48);
      8'h37: g = mk_glyph(7'd1, 7'd113, 7'd9, 7'd5, 7'd3);
      8'h38: g = mk_glyph(7'd54, 7'd73, 7'd73, 7'd73, 7'd54);
      8'h39: g = mk_glyph(7'd6, 7'd73, 7'd73, 7'd41, 7'd30);
      8'h41: g = mk_glyph(7'd126, 7'd17, 7'd17, 7'd17, 7'd126);
      8'h42: g = mk_glyph(7'd127, 7'd73, 7'd73, 7'd73, 7'd54);
      8'h43: g = mk_glyph(7'd62, 7'd65, 7'd65, 7'd65, 7'd34);
      8'h44: g = mk_glyph(7'd127, 7'd65, 7'd65, 7'd34, 7'd28);
      8'h45: g = mk_glyph(7'd127, 7'd73, 7'd73, 7'd73, 7'd65);
      8'h46: g = mk_glyph(7'd127, 7'd9, 7'd9, 7'd9, 7'd1);
      8'h47: g = mk_glyph(7'd62, 7'd65, 7'd73, 7'd73, 7'd122);
      8'h48: g = mk_glyph(7'd127, 7'd8, 7'd8, 7'd8, 7'd127);
      8'h49: g = mk_glyph(7'd0, 7'd65, 7'd127, 7'd65, 7'd0);
      8'h4A: g = mk_glyph(7'd32, 7'd64, 7'd65, 7'd63, 7'd1);
      8'h4B: g = mk_glyph(7'd127, 7'd8, 7'd20, 7'd34, 7'd65);
      8'h4C: g = mk_glyph(7'd127, 7'd64, 7'd64, 7'd64, 7'd64);
      8'h4D: g = mk_glyph(7'd127, 7'd2, 7'd12, 7'd2, 7'd127);
      8'h4E: g = mk_glyph(7'd127, 7'd4, 7'd8, 7'd16, 7'd127);
      8'h4F: g = mk_glyph(7'd62, 7'd65, 7'd65, 7'd65, 7'd62);
      8'h50: g = mk_glyph(7'd127, 7'd9, 7'd9, 7'd9, 7'd6);
      8'h51: g = mk_glyph(7'd62, 7'd65, 7'd81, 7'd33, 7'd94);
      8'h52: g = mk_glyph(7'd127, 7'd9, 7'd25, 7'd41, 7'd70);
      8'h53: g = mk_glyph(7'd70, 7'd73, 7'd73, 7'd73, 7'd49);
      8'h54: g = mk_glyph(7'd1, 7'd1, 7'd127, 7'd1, 7'd1);
      8'h55: g = mk_glyph(7'd63, 7'd64, 7'd64, 7'd64, 7'd63);
      8'h56: g = mk_glyph(7'd31, 7'd32, 7'd64, 7'd32, 7'd31);
      8'h57: g = mk_glyph(7'd63, 7'd64, 7'd56, 7'd64, 7'd63);
      8'h58: g = mk_glyph(7'd99, 7'd20, 7'd8, 7'd20, 7'd99);
      8'h59: g = mk_glyph(7'd3, 7'd4, 7'd120, 7'd4, 7'd3);
      8'h5A: g = mk_glyph(7'd97, 7'd81, 7'd73, 7'd69, 7'd67);
      default: g = mk_glyph(7'd2, 7'd1, 7'd81, 7'd9, 7'd6);
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== design/mono_framebuffer_text_renderer_core.sv =====
// Top level of the monochrome page frame store with 5x7 text rendering.
// Depends on mfb_pkg, mfb_front, mfb_queue and mfb_back.
//
//   port group | dir | words carried
//   in_*       | in  | command word: cmd, x, y, pixel_on, char_code, byte_index
//   out_*      | out | read_data word, one per read command
//
// Clear: a dispatch step, then a sweep that zeroes all 1024 bytes.
// Character: one read-modify-write per touched byte over 5 columns x 2 pages.
// After reset a clearing pass over all 1024 bytes runs with in_ready low.
// A stalled out word holds the next read; up to two words queue at the input.
`default_nettype none

module mono_framebuffer_text_renderer_core #(
  parameter int SCREEN_WIDTH  = mfb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = mfb_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_x,
  input  logic [7:0] in_y,
  input  logic       in_pixel_on,
  input  logic [7:0] in_char_code,
  input  logic [9:0] in_byte_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data
);
  import mfb_pkg::*;

  queue_stat_t q_stat;
  back_stat_t  b_stat;
  queue_word_t push_word, head_word;
  logic        push, pop;

  mfb_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_x          (in_x),
    .in_y          (in_y),
    .in_pixel_on   (in_pixel_on),
    .in_char_code  (in_char_code),
    .in_byte_index (in_byte_index),
    .q_stat        (q_stat),
    .b_stat        (b_stat),
    .push          (push),
    .push_word     (push_word)
  );

  mfb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head_word (head_word),
    .stat      (q_stat)
  );

  mfb_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_word     (head_word),
    .q_stat        (q_stat),
    .pop           (pop),
    .stat          (b_stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data)
  );

  a_init_after_reset: assert property (@(posedge clk)
    !rst_n |=> b_stat.init_busy)
    else $error("clearing pass not started after reset");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty command queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full && !b_stat.init_busy)
    else $error("word pushed into full queue or during clearing pass");

endmodule

`default_nettype wire

// ===== design/mfb_front.sv =====
// Front end: accepts input words, decodes commands and looks up glyphs.
// Depends on mfb_pkg; feeds mfb_queue.
`default_nettype none

module mfb_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  logic [7:0]           in_x,
  input  logic [7:0]           in_y,
  input  logic                 in_pixel_on,
  input  logic [7:0]           in_char_code,
  input  logic [9:0]           in_byte_index,
  input  mfb_pkg::queue_stat_t q_stat,
  input  mfb_pkg::back_stat_t  b_stat,
  output logic                 push,
  output mfb_pkg::queue_word_t push_word
);
  import mfb_pkg::*;

  glyph_t pix_glyph;

  assign in_ready = !q_stat.full && !b_stat.init_busy;
  assign push     = in_valid && in_ready;

  always_comb begin
    pix_glyph    = '0;
    pix_glyph[0] = {{(GLYPH_ROWS-1){1'b0}}, in_pixel_on};
  end

  always_comb begin
    push_word.kind      = in_cmd;
    push_word.x         = in_x;
    push_word.y         = in_y;
    push_word.read_addr = in_byte_index;
    if (in_cmd == CMD_CHAR) begin
      push_word.glyph    = glyph_lookup(in_char_code);
      push_word.row_en   = '1;
      push_word.last_col = COL_W'(GLYPH_COLS - 1);
    end else begin
      push_word.glyph    = pix_glyph;
      push_word.row_en   = GLYPH_ROWS'(1);
      push_word.last_col = '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/mfb_queue.sv =====
// Short command queue between front end and store engine.
// Depends on mfb_pkg.
`default_nettype none

module mfb_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mfb_pkg::queue_word_t push_word,
  input  logic                 pop,
  output mfb_pkg::queue_word_t head_word,
  output mfb_pkg::queue_stat_t stat
);
  import mfb_pkg::*;

  queue_word_t       slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

  assign head_word  = slot_r[rd_ptr_r];
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

endmodule

`default_nettype wire

// ===== design/mfb_back.sv =====
// Store engine: frame store memory, clear sweep, byte read-modify-write, readback.
// Depends on mfb_pkg; takes words from mfb_queue.
`default_nettype none

module mfb_back #(
  parameter int SCREEN_WIDTH  = mfb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = mfb_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mfb_pkg::queue_word_t head_word,
  input  mfb_pkg::queue_stat_t q_stat,
  output logic                 pop,
  output mfb_pkg::back_stat_t  stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_read_data
);
  import mfb_pkg::*;

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_OP    = 3'd2;
  localparam logic [2:0] ST_WR    = 3'd3;
  localparam logic [2:0] ST_RQ    = 3'd4;
  localparam logic [2:0] ST_RDATA = 3'd5;

  localparam logic [COORD_W-1:0] WIDTH_C  = COORD_W'(SCREEN_WIDTH);
  localparam logic [COORD_W-1:0] HEIGHT_C = COORD_W'(SCREEN_HEIGHT);

  logic [7:0]        store_r [STORE_DEPTH];
  logic [7:0]        mem_q_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [7:0]        mem_wd;

  logic [2:0]        state_r, state_nxt;
  queue_word_t       cur_r, cur_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              sel_r, sel_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic              init_r, init_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;

  logic [COORD_W-1:0]    op_x;
  logic [PAGE_W-1:0]     op_page;
  logic [GLYPH_ROWS-1:0] op_col_bits;
  logic [7:0]            op_mask, op_data;
  logic [ADDR_W-1:0]     op_addr;
  logic                  op_last, do_adv;

  // Byte target of the current column and page slot
  always_comb begin : op_calc
    logic [COORD_W-1:0] row_y;
    op_x        = cur_r.x + COORD_W'(col_r);
    op_page     = cur_r.y[COORD_W-1:3] + PAGE_W'(sel_r);
    op_col_bits = cur_r.glyph[col_r];
    op_mask     = '0;
    op_data     = '0;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      row_y = cur_r.y + COORD_W'(r);
      if (cur_r.row_en[r] && row_y[COORD_W-1:3] == op_page &&
          row_y < HEIGHT_C && op_x < WIDTH_C) begin
        op_mask[row_y[2:0]] = 1'b1;
        op_data[row_y[2:0]] = op_col_bits[r];
      end
    end
    op_addr = ADDR_W'(op_x) + ADDR_W'(op_page) * ADDR_W'(SCREEN_WIDTH);
    op_last = sel_r && (col_r == cur_r.last_col);
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    col_nxt       = col_r;
    sel_nxt       = sel_r;
    sweep_nxt     = sweep_r;
    init_nxt      = init_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = op_addr;
    mem_wd        = (mem_q_r & ~op_mask) | (op_data & op_mask);
    mem_re        = 1'b0;
    mem_ra        = op_addr;
    do_adv        = 1'b0;

    unique case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = sweep_r;
        mem_wd = '0;
        if (sweep_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
          init_nxt  = 1'b0;
        end else begin
          sweep_nxt = sweep_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          cur_nxt   = head_word;
          col_nxt   = '0;
          sel_nxt   = 1'b0;
          sweep_nxt = '0;
          unique case (head_word.kind)
            CMD_CLEAR: state_nxt = ST_CLR;
            CMD_PIXEL: state_nxt = ST_OP;
            CMD_CHAR:  state_nxt = ST_OP;
            CMD_READ:  state_nxt = ST_RQ;
          endcase
        end
      end
      ST_OP: begin
        if (op_mask != '0) begin
          mem_re    = 1'b1;
          state_nxt = ST_WR;
        end else begin
          do_adv = 1'b1;
        end
      end
      ST_WR: begin
        mem_we = 1'b1;
        do_adv = 1'b1;
      end
      ST_RQ: begin
        if (!out_valid_r) begin
          mem_re    = 1'b1;
          mem_ra    = cur_r.read_addr;
          state_nxt = ST_RDATA;
        end
      end
      ST_RDATA: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = mem_q_r;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Advance to the next page slot, then the next column
    if (do_adv) begin
      if (op_last) begin
        state_nxt = ST_IDLE;
      end else if (sel_r) begin
        sel_nxt   = 1'b0;
        col_nxt   = col_r + COL_W'(1);
        state_nxt = ST_OP;
      end else begin
        sel_nxt   = 1'b1;
        state_nxt = ST_OP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      col_r       <= '0;
      sel_r       <= 1'b0;
      sweep_r     <= '0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      sel_r       <= sel_nxt;
      sweep_r     <= sweep_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= store_r[mem_ra];
    end
  end

  assign stat.init_busy = init_r;
  assign out_valid      = out_valid_r;
  assign out_read_data  = out_data_r;

endmodule

`default_nettype wire
